// ===== hw/rtl/tpc_pkg.sv =====
package tpc_pkg;

    // fixed widths of the datapath
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = COORD_W + DIFF_W;
    localparam int DIST_W     = PROD_W + 1;
    localparam int DEN_W      = DIST_W;
    localparam int MAG_W      = COORD_W;
    localparam int NUM_W      = DEN_W + MAG_W - 1;
    localparam int CHUNK_W    = 22;
    localparam int NUM_CHUNKS = 3;
    localparam int CNT_W      = $clog2(MAG_W);
    localparam int CFG_IDX_W  = 3;

    localparam int TPC_QUEUE_DEPTH = 4;

    localparam logic signed [COORD_W-1:0] NORMAL_Z_RESET = 32'sd65536;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X = 3'd0,
        CFG_NORMAL_Y = 3'd1,
        CFG_NORMAL_Z = 3'd2,
        CFG_POINT_X  = 3'd3,
        CFG_POINT_Y  = 3'd4,
        CFG_POINT_Z  = 3'd5
    } cfg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIST_W-1:0]  dist_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    typedef vec_t  [2:0] vtx3_t;
    typedef dist_t [2:0] dist3_t;

    typedef struct packed {
        coord_t a_x;
        coord_t a_y;
        coord_t a_z;
        coord_t b_x;
        coord_t b_y;
        coord_t b_z;
        coord_t c_x;
        coord_t c_y;
        coord_t c_z;
    } tri_t;

    typedef struct packed {
        coord_t out_a_x;
        coord_t out_a_y;
        coord_t out_a_z;
        coord_t out_b_x;
        coord_t out_b_y;
        coord_t out_b_z;
        coord_t out_c_x;
        coord_t out_c_y;
        coord_t out_c_z;
        logic   last_of_run;
    } res_t;

    // classified triangle waiting for the back end
    typedef struct packed {
        vtx3_t      vtx;
        dist3_t     dists;
        logic [2:0] in_mask;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CROSS0,
        BK_CROSS1,
        BK_EMIT0,
        BK_EMIT1
    } back_state_t;

    typedef enum logic [1:0] {
        CX_IDLE,
        CX_MUL,
        CX_DIV,
        CX_FIN
    } cx_state_t;

    typedef enum logic [1:0] {
        OK_PASS,
        OK_ONE,
        OK_FIRST,
        OK_SECOND
    } out_kind_t;

    function automatic vtx3_t tri_to_vtx(tri_t t);
        vtx3_t v;
        v[0] = '{x: t.a_x, y: t.a_y, z: t.a_z};
        v[1] = '{x: t.b_x, y: t.b_y, z: t.b_z};
        v[2] = '{x: t.c_x, y: t.c_y, z: t.c_z};
        return v;
    endfunction

    function automatic res_t make_res(vec_t p, vec_t q, vec_t r, logic last);
        res_t o;
        o.out_a_x     = p.x;
        o.out_a_y     = p.y;
        o.out_a_z     = p.z;
        o.out_b_x     = q.x;
        o.out_b_y     = q.y;
        o.out_b_z     = q.z;
        o.out_c_x     = r.x;
        o.out_c_y     = r.y;
        o.out_c_z     = r.z;
        o.last_of_run = last;
        return o;
    endfunction

    function automatic logic [1:0] count3(logic [2:0] m);
        return 2'(m[0]) + 2'(m[1]) + 2'(m[2]);
    endfunction

    // index of the first (second when n is set) set bit, in A, B, C order
    function automatic logic [1:0] nth_idx(logic [2:0] m, logic n);
        logic [1:0] first;
        logic [1:0] second;
        first  = m[0] ? 2'd0 : (m[1] ? 2'd1 : 2'd2);
        second = (m[0] && m[1]) ? 2'd1 : 2'd2;
        return n ? second : first;
    endfunction

endpackage

// ===== hw/rtl/tpc_stream_if.sv =====
interface tpc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tpc_front.sv =====
module tpc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpc_pkg::COORD_W-1:0]    cfg_data,
    tpc_stream_if.sink                     tri_in,
    input  tpc_pkg::q_stat_t               q_stat,
    output logic                           push,
    output tpc_pkg::entry_t                push_entry
);
    import tpc_pkg::*;

    coord_t normal_reg [3];
    coord_t point_reg  [3];

    logic                      s1_valid_reg;
    vtx3_t                     s1_vtx_reg;
    logic signed [DIFF_W-1:0]  s1_diff_reg [3][3];

    logic                      s2_valid_reg;
    vtx3_t                     s2_vtx_reg;
    logic signed [PROD_W-1:0]  s2_prod_reg [3][3];

    logic   en1;
    logic   en2;
    vtx3_t  in_vtx;
    dist3_t dists;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg[0] <= '0;
            normal_reg[1] <= '0;
            normal_reg[2] <= NORMAL_Z_RESET;
            point_reg[0]  <= '0;
            point_reg[1]  <= '0;
            point_reg[2]  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_NORMAL_X: normal_reg[0] <= cfg_data;
                CFG_NORMAL_Y: normal_reg[1] <= cfg_data;
                CFG_NORMAL_Z: normal_reg[2] <= cfg_data;
                CFG_POINT_X:  point_reg[0]  <= cfg_data;
                CFG_POINT_Y:  point_reg[1]  <= cfg_data;
                CFG_POINT_Z:  point_reg[2]  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // pipeline advance
    assign push         = s2_valid_reg && !q_stat.full;
    assign en2          = !s2_valid_reg || !q_stat.full;
    assign en1          = !s1_valid_reg || en2;
    assign tri_in.ready = en1;
    assign in_vtx       = tri_to_vtx(tri_in.data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= tri_in.valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // stage one: offsets from the plane point
    always_ff @(posedge clk)
    begin
        if (en1 && tri_in.valid)
        begin
            s1_vtx_reg <= in_vtx;
            for (int v = 0; v < 3; v++)
            begin
                s1_diff_reg[v][0] <= DIFF_W'(in_vtx[v].x) - DIFF_W'(point_reg[0]);
                s1_diff_reg[v][1] <= DIFF_W'(in_vtx[v].y) - DIFF_W'(point_reg[1]);
                s1_diff_reg[v][2] <= DIFF_W'(in_vtx[v].z) - DIFF_W'(point_reg[2]);
            end
        end
    end

    // stage two: exact products with the normal
    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            s2_vtx_reg <= s1_vtx_reg;
            for (int v = 0; v < 3; v++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    s2_prod_reg[v][c] <= PROD_W'(normal_reg[c]) * PROD_W'(s1_diff_reg[v][c]);
                end
            end
        end
    end

    // distance sum and inside test
    always_comb
    begin
        for (int v = 0; v < 3; v++)
        begin
            dists[v] = DIST_W'(s2_prod_reg[v][0]) + DIST_W'(s2_prod_reg[v][1])
                     + DIST_W'(s2_prod_reg[v][2]);
        end
        push_entry.vtx   = s2_vtx_reg;
        push_entry.dists = dists;
        for (int v = 0; v < 3; v++)
        begin
            push_entry.in_mask[v] = !dists[v][DIST_W-1];
        end
    end

endmodule

// ===== hw/rtl/tpc_queue.sv =====
module tpc_queue #(
    parameter int DEPTH = tpc_pkg::TPC_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tpc_pkg::entry_t   push_entry,
    input  logic              pop,
    output tpc_pkg::entry_t   head,
    output tpc_pkg::q_stat_t  q_stat
);
    import tpc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/tpc_cross.sv =====
module tpc_cross (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  tpc_pkg::coord_t             a_c,
    input  tpc_pkg::coord_t             b_c,
    input  tpc_pkg::dist_t              da,
    input  logic [tpc_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output tpc_pkg::coord_t             result
);
    import tpc_pkg::*;

    localparam int MULT_W = CHUNK_W * NUM_CHUNKS;
    localparam int PP_W   = CHUNK_W + MAG_W;

    cx_state_t                 state_reg;
    cx_state_t                 state_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [MULT_W-1:0]         da_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic                      neg_reg;
    coord_t                    a_reg;
    logic [NUM_W-1:0]          num_reg;
    logic [NUM_W-1:0]          dsh_reg;
    logic [MAG_W-1:0]          q_reg;

    logic                      can_start;
    logic signed [DIFF_W-1:0]  diff;
    logic [PP_W-1:0]           pp;
    logic [NUM_W:0]            sub;
    logic                      fits;
    logic signed [COORD_W+1:0] aext;
    logic signed [COORD_W+1:0] qext;
    logic signed [COORD_W+1:0] sum;

    assign can_start = (state_reg == CX_IDLE) || (state_reg == CX_FIN);
    assign diff      = DIFF_W'(b_c) - DIFF_W'(a_c);
    assign pp        = PP_W'(da_reg[MULT_W-1 -: CHUNK_W]) * PP_W'(mag_reg);
    assign sub       = {1'b0, num_reg} - {1'b0, dsh_reg};
    assign fits      = !sub[NUM_W];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CX_IDLE:
            begin
                if (start)
                begin
                    state_next = CX_MUL;
                end
            end
            CX_MUL:
            begin
                if (cnt_reg == CNT_W'(NUM_CHUNKS - 1))
                begin
                    state_next = CX_DIV;
                end
            end
            CX_DIV:
            begin
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    state_next = CX_FIN;
                end
            end
            CX_FIN:
            begin
                state_next = start ? CX_MUL : CX_IDLE;
            end
            default: state_next = CX_IDLE;
        endcase
    end

    // final add and clamp
    always_comb
    begin
        aext = (COORD_W + 2)'(a_reg);
        qext = $signed({2'b00, q_reg});
        sum  = neg_reg ? aext - qext : aext + qext;
        if ((sum[COORD_W+1:COORD_W-1] == 3'b000) || (sum[COORD_W+1:COORD_W-1] == 3'b111))
        begin
            result = sum[COORD_W-1:0];
        end
        else if (sum[COORD_W+1])
        begin
            result = {1'b1, {(COORD_W - 1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(COORD_W - 1){1'b1}}};
        end
        done = (state_reg == CX_FIN);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CX_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (start && can_start)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == CX_MUL && cnt_reg == CNT_W'(NUM_CHUNKS - 1))
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == CX_MUL || state_reg == CX_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // multiply by chunks from the top, then restoring divide
    always_ff @(posedge clk)
    begin
        if (start && can_start)
        begin
            a_reg   <= a_c;
            neg_reg <= diff[DIFF_W-1];
            mag_reg <= MAG_W'(diff[DIFF_W-1] ? -diff : diff);
            da_reg  <= MULT_W'(da[DIST_W-2:0]);
            num_reg <= '0;
            dsh_reg <= NUM_W'(den) << (MAG_W - 1);
            q_reg   <= '0;
        end
        else if (state_reg == CX_MUL)
        begin
            num_reg <= (num_reg << CHUNK_W) + NUM_W'(pp);
            da_reg  <= da_reg << CHUNK_W;
        end
        else if (state_reg == CX_DIV)
        begin
            if (fits)
            begin
                num_reg <= sub[NUM_W-1:0];
            end
            q_reg   <= {q_reg[MAG_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

endmodule

// ===== hw/rtl/tpc_back.sv =====
module tpc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  tpc_pkg::entry_t   head,
    input  tpc_pkg::q_stat_t  q_stat,
    output logic              pop,
    tpc_stream_if.source      res_out
);
    import tpc_pkg::*;

    back_state_t  state_reg;
    back_state_t  state_next;
    entry_t       wk_reg;
    vec_t         x0_reg;
    vec_t         x1_reg;
    logic         out_valid_reg;
    res_t         out_data_reg;

    logic         out_free;
    logic [1:0]   head_n;
    logic         start;
    logic         wk_load;
    logic         x0_load;
    logic         x1_load;
    logic         out_load;
    out_kind_t    out_kind;

    entry_t       src;
    logic [1:0]   src_n;
    logic [1:0]   ia;
    logic [1:0]   ob;
    vec_t         av;
    vec_t         bv;
    dist_t        da_s;
    dist_t        db_s;
    logic [DEN_W-1:0] den;
    logic [2:0]   cdone;
    vec_t         xr;

    logic [1:0]   wk_n;
    logic [1:0]   w_ins0;
    logic [1:0]   w_ins1;
    res_t         out_next;

    assign out_free = !out_valid_reg || res_out.ready;
    assign head_n   = count3(head.in_mask);
    assign wk_n     = count3(wk_reg.in_mask);
    assign w_ins0   = nth_idx(wk_reg.in_mask, 1'b0);
    assign w_ins1   = nth_idx(wk_reg.in_mask, 1'b1);

    // crossing endpoints: first crossing from the queue head, second from the held item
    always_comb
    begin
        src   = (state_reg == BK_IDLE) ? head : wk_reg;
        src_n = count3(src.in_mask);
        if (state_reg != BK_IDLE && src_n == 2'd2)
        begin
            ia = nth_idx(src.in_mask, 1'b1);
        end
        else
        begin
            ia = nth_idx(src.in_mask, 1'b0);
        end
        if (state_reg != BK_IDLE && src_n == 2'd1)
        begin
            ob = nth_idx(~src.in_mask, 1'b1);
        end
        else
        begin
            ob = nth_idx(~src.in_mask, 1'b0);
        end
        av   = src.vtx[ia];
        bv   = src.vtx[ob];
        da_s = src.dists[ia];
        db_s = src.dists[ob];
        den  = DEN_W'(da_s - db_s);
    end

    // one crossing unit per coordinate
    tpc_cross u_cross_x (
        .clk(clk), .rst_n(rst_n), .start(start), .a_c(av.x), .b_c(bv.x),
        .da(da_s), .den(den), .done(cdone[0]), .result(xr.x)
    );
    tpc_cross u_cross_y (
        .clk(clk), .rst_n(rst_n), .start(start), .a_c(av.y), .b_c(bv.y),
        .da(da_s), .den(den), .done(cdone[1]), .result(xr.y)
    );
    tpc_cross u_cross_z (
        .clk(clk), .rst_n(rst_n), .start(start), .a_c(av.z), .b_c(bv.z),
        .da(da_s), .den(den), .done(cdone[2]), .result(xr.z)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty && (head_n == 2'd1 || head_n == 2'd2))
                begin
                    state_next = BK_CROSS0;
                end
            end
            BK_CROSS0:
            begin
                if (cdone[0])
                begin
                    state_next = BK_CROSS1;
                end
            end
            BK_CROSS1:
            begin
                if (cdone[0])
                begin
                    state_next = BK_EMIT0;
                end
            end
            BK_EMIT0:
            begin
                if (out_free)
                begin
                    state_next = (wk_n == 2'd2) ? BK_EMIT1 : BK_IDLE;
                end
            end
            BK_EMIT1:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        pop      = 1'b0;
        start    = 1'b0;
        wk_load  = 1'b0;
        x0_load  = 1'b0;
        x1_load  = 1'b0;
        out_load = 1'b0;
        out_kind = OK_PASS;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    case (head_n)
                        2'd0:
                        begin
                            pop = 1'b1;
                        end
                        2'd3:
                        begin
                            pop      = out_free;
                            out_load = out_free;
                        end
                        default:
                        begin
                            pop     = 1'b1;
                            start   = 1'b1;
                            wk_load = 1'b1;
                        end
                    endcase
                end
            end
            BK_CROSS0:
            begin
                x0_load = cdone[0];
                start   = cdone[0];
            end
            BK_CROSS1:
            begin
                x1_load = cdone[0];
            end
            BK_EMIT0:
            begin
                out_load = out_free;
                out_kind = (wk_n == 2'd2) ? OK_FIRST : OK_ONE;
            end
            BK_EMIT1:
            begin
                out_load = out_free;
                out_kind = OK_SECOND;
            end
            default: ;
        endcase
    end

    // result triangle select
    always_comb
    begin
        case (out_kind)
            OK_PASS:   out_next = make_res(head.vtx[0], head.vtx[1], head.vtx[2], 1'b1);
            OK_ONE:    out_next = make_res(wk_reg.vtx[w_ins0], x0_reg, x1_reg, 1'b1);
            OK_FIRST:  out_next = make_res(wk_reg.vtx[w_ins0], wk_reg.vtx[w_ins1], x0_reg, 1'b0);
            OK_SECOND: out_next = make_res(wk_reg.vtx[w_ins1], x0_reg, x1_reg, 1'b1);
            default:   out_next = make_res(head.vtx[0], head.vtx[1], head.vtx[2], 1'b1);
        endcase
    end

    assign res_out.valid = out_valid_reg;
    assign res_out.data  = out_data_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // held item, crossings and output register
    always_ff @(posedge clk)
    begin
        if (wk_load)
        begin
            wk_reg <= head;
        end
        if (x0_load)
        begin
            x0_reg <= xr;
        end
        if (x1_load)
        begin
            x1_reg <= xr;
        end
        if (out_load)
        begin
            out_data_reg <= out_next;
        end
    end

endmodule

// ===== hw/rtl/triangle_plane_clipper_top.sv =====
// channel   dir  handshake      payload
// tri_in    in   valid/ready    tri_t: a_x .. c_z, signed Q16.16
// res_out   out  valid/ready    res_t: out_a_x .. out_c_z, last_of_run
// cfg       in   cfg_we         cfg_index selects the register, cfg_data is written
//
// triangles with all vertices inside or all outside move at one per cycle
// while the back end is idle and the output is not stalled. a clipped
// triangle holds the back end for two crossings in turn, each 3 multiply
// steps, 32 restoring divide steps and 1 finish step in the per-coordinate
// crossing units, then while its result triangles leave the output register.
// rst_n is asynchronous; it loads the plane registers and empties the queue.
// the front keeps accepting while the queue has room; a stalled output holds
// the back end only.
module triangle_plane_clipper_top #(
    parameter int QUEUE_DEPTH = tpc_pkg::TPC_QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpc_pkg::COORD_W-1:0]    cfg_data,
    tpc_stream_if.sink                     tri_in,
    tpc_stream_if.source                   res_out
);
    import tpc_pkg::*;

    logic     push;
    logic     pop;
    entry_t   push_entry;
    entry_t   head;
    q_stat_t  q_stat;

    // distance and classification
    tpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tri_in     (tri_in),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    // queue between front and back
    tpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    // clipping and result emission
    tpc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_stat  (q_stat),
        .pop     (pop),
        .res_out (res_out)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.ready && !res_out.data.last_of_run) |=> res_out.valid)
        else $error("second triangle of a pair not presented");
`endif

endmodule
